// ----- rtl/core/pdec_pkg.sv -----
// Shared types, constants and helpers for the particle drift and collide core.
`default_nettype none
package pdec_pkg;

    localparam int MAX_PARTICLES = 256;
    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = IDX_W + 1;
    localparam int W    = 128;

    localparam logic [1:0] CFG_COUNT  = 2'd0;
    localparam logic [1:0] CFG_DT     = 2'd1;
    localparam logic [1:0] CFG_ENABLE = 2'd2;

    localparam logic [39:0] DT_RESET = 40'd1099512;

    localparam logic signed [W-1:0] SAT_HI = 128'sd140737488355327;
    localparam logic signed [W-1:0] SAT_LO = -128'sd140737488355328;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ALU_NOP,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIX,
        A_DONE
    } t_alu_state;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
    } t_alu_rsp;

    typedef enum logic [5:0] {
        S_IDLE, S_RD_W, S_RD_OUT,
        S_DR_START, S_DR_W, S_DR_MX, S_DR_MY, S_DR_WB,
        S_PR_START, S_PJ_START, S_PI_W, S_PI_LD, S_PJ_W, S_PJ_LD,
        S_C_DIFF, S_C_D2X, S_C_D2Y, S_C_DS, S_C_CHK,
        S_C_DOTX, S_C_DOTY, S_C_Q,
        S_C_QX, S_C_RX, S_C_RXD, S_C_QY, S_C_RY, S_C_RYD, S_C_U,
        S_C_MXI, S_C_MXJ, S_C_CMX, S_C_MYI, S_C_MYJ, S_C_CMY,
        S_C_VXI, S_C_VXID, S_C_VYI, S_C_VYID, S_C_WI,
        S_C_VXJ, S_C_VXJD, S_C_VYJ, S_C_VYJD, S_C_WJ,
        S_NEXT
    } t_seq_state;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  index;
        logic [31:0] mass;
        logic [47:0] pos_x;
        logic [47:0] pos_y;
        logic [47:0] vel_x;
        logic [47:0] vel_y;
        logic [39:0] radius;
        logic        leaked;
    } t_item;

    typedef struct packed {
        logic [7:0]  slot;
        logic [47:0] pos_x;
        logic [47:0] pos_y;
        logic [47:0] vel_x;
        logic [47:0] vel_y;
        logic        leaked;
    } t_result;

    typedef struct packed {
        logic [31:0] mass;
        logic [47:0] px;
        logic [47:0] py;
        logic [47:0] vx;
        logic [47:0] vy;
        logic [39:0] rad;
        logic        leak;
    } t_part;

    function automatic logic signed [W-1:0] sx48(input logic [47:0] x);
        return {{(W-48){x[47]}}, x};
    endfunction

    function automatic logic [47:0] sat48(input logic signed [W-1:0] v);
        if (v > SAT_HI) return 48'h7FFF_FFFF_FFFF;
        if (v < SAT_LO) return 48'h8000_0000_0000;
        return v[47:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pdec_alu.sv -----
// Shared serial multiply / floor-divide unit on 128-bit signed values.
`default_nettype none
module pdec_alu
    import pdec_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_alu_req            i_req,
    input  wire logic signed [W-1:0] i_a,
    input  wire logic signed [W-1:0] i_b,
    output t_alu_rsp                 o_rsp,
    output logic signed [W-1:0]      o_res,
    output logic signed [W-1:0]      o_rem
);

    t_alu_state r_st, n_st;
    t_alu_op    r_op, n_op;
    logic       r_neg, n_neg;
    logic [W-1:0] r_x, n_x, r_y, n_y, r_acc, n_acc;
    logic [6:0]   r_cnt, n_cnt;
    logic signed [W-1:0] r_res, n_res, r_rem, n_rem;
    logic [W-1:0] sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= A_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_op  <= n_op;
        r_neg <= n_neg;
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        r_res <= n_res;
        r_rem <= n_rem;
    end

    always_comb begin
        n_st  = r_st;
        n_op  = r_op;
        n_neg = r_neg;
        n_x   = r_x;
        n_y   = r_y;
        n_acc = r_acc;
        n_cnt = r_cnt;
        n_res = r_res;
        n_rem = r_rem;
        sh    = {r_acc[W-2:0], r_x[W-1]};
        case (r_st)
            A_IDLE: begin
                if (i_req.start) begin
                    n_op  = i_req.op;
                    n_x   = i_a[W-1] ? -i_a : i_a;
                    n_y   = i_b[W-1] ? -i_b : i_b;
                    n_acc = '0;
                    if (i_req.op == ALU_MUL) begin
                        n_neg = i_a[W-1] ^ i_b[W-1];
                        n_cnt = 7'd63;
                        n_st  = A_MUL;
                    end else begin
                        n_neg = i_a[W-1];
                        n_cnt = 7'd127;
                        n_st  = A_DIV;
                    end
                end
            end
            A_MUL: begin
                // multiplier magnitude sits in the low 64 bits, MSB first
                n_acc = {r_acc[W-2:0], 1'b0} + (r_y[63] ? r_x : '0);
                n_y   = {r_y[W-2:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd0) n_st = A_FIX;
            end
            A_DIV: begin
                // restoring step; quotient bits shift into r_x
                if (sh >= r_y) begin
                    n_acc = sh - r_y;
                    n_x   = {r_x[W-2:0], 1'b1};
                end else begin
                    n_acc = sh;
                    n_x   = {r_x[W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd0) n_st = A_FIX;
            end
            A_FIX: begin
                if (r_op == ALU_MUL) begin
                    n_res = r_neg ? -r_acc : r_acc;
                    n_rem = '0;
                end else if (r_neg && (r_acc != '0)) begin
                    // floor of a negative quotient: -(q+1) == ~q
                    n_res = ~r_x;
                    n_rem = r_y - r_acc;
                end else begin
                    n_res = r_neg ? -r_x : r_x;
                    n_rem = r_acc;
                end
                n_st = A_DONE;
            end
            A_DONE: n_st = A_IDLE;
            default: n_st = A_IDLE;
        endcase
    end

    assign o_rsp.done = (r_st == A_DONE);
    assign o_res = r_res;
    assign o_rem = r_rem;

endmodule
`default_nettype wire

// ----- rtl/core/pdec_seq.sv -----
// Command sequencer, particle table and the drift / collision microsequence.
`default_nettype none
module pdec_seq
    import pdec_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_acc,
    input  wire t_item               i_item,
    input  wire logic [8:0]          i_count,
    input  wire logic [39:0]         i_dt,
    input  wire logic                i_en,
    input  wire logic                i_out_free,
    output logic                     o_idle,
    output logic                     o_res_valid,
    output t_result                  o_res,
    output t_alu_req                 o_alu_req,
    output logic signed [W-1:0]      o_alu_a,
    output logic signed [W-1:0]      o_alu_b,
    input  wire t_alu_rsp            i_alu_rsp,
    input  wire logic signed [W-1:0] i_alu_res,
    input  wire logic signed [W-1:0] i_alu_rem
);

    logic [31:0] r_mem_m  [MAX_PARTICLES];
    logic [47:0] r_mem_px [MAX_PARTICLES];
    logic [47:0] r_mem_py [MAX_PARTICLES];
    logic [47:0] r_mem_vx [MAX_PARTICLES];
    logic [47:0] r_mem_vy [MAX_PARTICLES];
    logic [39:0] r_mem_r  [MAX_PARTICLES];
    logic        r_mem_l  [MAX_PARTICLES];

    t_seq_state r_st, n_st;
    logic r_wait, n_wait;
    logic [CNT_W-1:0] r_i, n_i, r_j, n_j;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic r_oob, n_oob;
    logic [7:0] r_slot, n_slot;
    t_part r_rd, r_pi, n_pi, r_pj, n_pj;
    logic signed [W-1:0] r_dx, n_dx, r_dy, n_dy, r_d2, n_d2, r_t, n_t;
    logic signed [W-1:0] r_q, n_q, r_rm, n_rm, r_ux, n_ux, r_uy, n_uy;
    logic signed [W-1:0] r_cx, n_cx, r_cy, n_cy, r_cmx, n_cmx, r_cmy, n_cmy;
    logic [47:0] r_nx, n_nx, r_ny, n_ny;

    logic [CNT_W-1:0] lim;
    logic [32:0] mw;
    logic [40:0] ds;
    logic op_fin;
    logic wr_all, wr_pos, wr_vel;
    logic [IDX_W-1:0] wr_addr;

    assign mw = {1'b0, r_pi.mass} + {1'b0, r_pj.mass};
    assign ds = {1'b0, r_pi.rad} + {1'b0, r_pj.rad};
    assign op_fin = r_wait && i_alu_rsp.done;

    always_comb begin
        if (32'(i_count) > 32'(MAX_PARTICLES)) lim = CNT_W'(MAX_PARTICLES);
        else lim = CNT_W'(i_count);
    end

    // table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_all) begin
            r_mem_m[wr_addr] <= i_item.mass;
            r_mem_r[wr_addr] <= i_item.radius;
            r_mem_l[wr_addr] <= i_item.leaked;
            r_mem_px[wr_addr] <= i_item.pos_x;
            r_mem_py[wr_addr] <= i_item.pos_y;
            r_mem_vx[wr_addr] <= i_item.vel_x;
            r_mem_vy[wr_addr] <= i_item.vel_y;
        end
        if (wr_pos) begin
            r_mem_px[wr_addr] <= r_nx;
            r_mem_py[wr_addr] <= r_ny;
        end
        if (wr_vel) begin
            r_mem_vx[wr_addr] <= r_nx;
            r_mem_vy[wr_addr] <= r_ny;
        end
        r_rd.mass <= r_mem_m[r_addr];
        r_rd.px   <= r_mem_px[r_addr];
        r_rd.py   <= r_mem_py[r_addr];
        r_rd.vx   <= r_mem_vx[r_addr];
        r_rd.vy   <= r_mem_vy[r_addr];
        r_rd.rad  <= r_mem_r[r_addr];
        r_rd.leak <= r_mem_l[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_wait <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_wait <= n_wait;
        end
        r_i <= n_i;     r_j <= n_j;     r_addr <= n_addr;
        r_oob <= n_oob; r_slot <= n_slot;
        r_pi <= n_pi;   r_pj <= n_pj;
        r_dx <= n_dx;   r_dy <= n_dy;   r_d2 <= n_d2;   r_t <= n_t;
        r_q <= n_q;     r_rm <= n_rm;   r_ux <= n_ux;   r_uy <= n_uy;
        r_cx <= n_cx;   r_cy <= n_cy;   r_cmx <= n_cmx; r_cmy <= n_cmy;
        r_nx <= n_nx;   r_ny <= n_ny;
    end

    always_comb begin
        n_st = r_st;     n_i = r_i;     n_j = r_j;     n_addr = r_addr;
        n_oob = r_oob;   n_slot = r_slot;
        n_pi = r_pi;     n_pj = r_pj;
        n_dx = r_dx;     n_dy = r_dy;   n_d2 = r_d2;   n_t = r_t;
        n_q = r_q;       n_rm = r_rm;   n_ux = r_ux;   n_uy = r_uy;
        n_cx = r_cx;     n_cy = r_cy;   n_cmx = r_cmx; n_cmy = r_cmy;
        n_nx = r_nx;     n_ny = r_ny;
        o_alu_req.op = ALU_NOP;
        o_alu_a = '0;
        o_alu_b = '0;
        o_res_valid = 1'b0;
        wr_all = 1'b0;
        wr_pos = 1'b0;
        wr_vel = 1'b0;
        wr_addr = IDX_W'(r_i);

        case (r_st)
            S_IDLE: begin
                if (i_acc) begin
                    case (t_cmd'(i_item.cmd))
                        CMD_WRITE: begin
                            wr_addr = IDX_W'(i_item.index);
                            wr_all  = (32'(i_item.index) < 32'(MAX_PARTICLES));
                        end
                        CMD_STEP: begin
                            n_i  = '0;
                            n_st = S_DR_START;
                        end
                        CMD_READ: begin
                            n_addr = IDX_W'(i_item.index);
                            n_oob  = !(32'(i_item.index) < 32'(MAX_PARTICLES));
                            n_slot = i_item.index;
                            n_st   = S_RD_W;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD_W: n_st = S_RD_OUT;
            S_RD_OUT: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_st = S_IDLE;
                end
            end

            // drift pass
            S_DR_START: begin
                if (r_i < lim) begin
                    n_addr = IDX_W'(r_i);
                    n_st   = S_DR_W;
                end else if (i_en) begin
                    n_i  = '0;
                    n_st = S_PR_START;
                end else begin
                    n_st = S_IDLE;
                end
            end
            S_DR_W: n_st = S_DR_MX;
            S_DR_MX: begin
                o_alu_req.op = ALU_MUL;
                o_alu_a = sx48(r_rd.vx);
                o_alu_b = {{(W-40){1'b0}}, i_dt};
                if (op_fin) begin
                    n_nx = sat48(sx48(r_rd.px) + (i_alu_res >>> 32));
                    n_st = S_DR_MY;
                end
            end
            S_DR_MY: begin
                o_alu_req.op = ALU_MUL;
                o_alu_a = sx48(r_rd.vy);
                o_alu_b = {{(W-40){1'b0}}, i_dt};
                if (op_fin) begin
                    n_ny = sat48(sx48(r_rd.py) + (i_alu_res >>> 32));
                    n_st = S_DR_WB;
                end
            end
            S_DR_WB: begin
                wr_pos = 1'b1;
                n_i    = r_i + 1'b1;
                n_st   = S_DR_START;
            end

            // pair pass
            S_PR_START: begin
                if ((CNT_W+1)'(r_i) + 1'b1 < (CNT_W+1)'(lim)) begin
                    n_j  = r_i + 1'b1;
                    n_st = S_PJ_START;
                end else begin
                    n_st = S_IDLE;
                end
            end
            S_PJ_START: begin
                if (r_j < lim) begin
                    n_addr = IDX_W'(r_i);
                    n_st   = S_PI_W;
                end else begin
                    n_i  = r_i + 1'b1;
                    n_st = S_PR_START;
                end
            end
            S_PI_W: n_st = S_PI_LD;
            S_PI_LD: begin
                n_pi   = r_rd;
                n_addr = IDX_W'(r_j);
                n_st   = S_PJ_W;
            end
            S_PJ_W: n_st = S_PJ_LD;
            S_PJ_LD: begin
                n_pj = r_rd;
                n_st = S_C_DIFF;
            end
            S_C_DIFF: begin
                n_dx = sx48(r_pi.px) - sx48(r_pj.px);
                n_dy = sx48(r_pi.py) - sx48(r_pj.py);
                n_ux = sx48(r_pi.vx) - sx48(r_pj.vx);
                n_uy = sx48(r_pi.vy) - sx48(r_pj.vy);
                n_st = (r_pi.leak || r_pj.leak) ? S_NEXT : S_C_D2X;
            end
            S_C_D2X: begin
                o_alu_req.op = ALU_MUL; o_alu_a = r_dx; o_alu_b = r_dx;
                if (op_fin) begin n_d2 = i_alu_res; n_st = S_C_D2Y; end
            end
            S_C_D2Y: begin
                o_alu_req.op = ALU_MUL; o_alu_a = r_dy; o_alu_b = r_dy;
                if (op_fin) begin n_d2 = r_d2 + i_alu_res; n_st = S_C_DS; end
            end
            S_C_DS: begin
                o_alu_req.op = ALU_MUL;
                o_alu_a = {{(W-41){1'b0}}, ds};
                o_alu_b = {{(W-41){1'b0}}, ds};
                if (op_fin) begin n_t = i_alu_res; n_st = S_C_CHK; end
            end
            S_C_CHK: begin
                // overlap test, then zero distance and zero mass are skipped
                if ((r_d2 < r_t) && (r_d2 != '0) && (mw != '0)) n_st = S_C_DOTX;
                else n_st = S_NEXT;
            end
            S_C_DOTX: begin
                o_alu_req.op = ALU_MUL; o_alu_a = r_ux; o_alu_b = r_dx;
                if (op_fin) begin n_t = i_alu_res; n_st = S_C_DOTY; end
            end
            S_C_DOTY: begin
                o_alu_req.op = ALU_MUL; o_alu_a = r_uy; o_alu_b = r_dy;
                if (op_fin) begin n_t = r_t + i_alu_res; n_st = S_C_Q; end
            end
            S_C_Q: begin
                o_alu_req.op = ALU_DIV; o_alu_a = {r_t[W-2:0], 1'b0}; o_alu_b = r_d2;
                if (op_fin) begin n_q = i_alu_res; n_rm = i_alu_rem; n_st = S_C_QX; end
            end
            S_C_QX: begin
                o_alu_req.op = ALU_MUL; o_alu_a = r_q; o_alu_b = r_dx;
                if (op_fin) begin n_cx = i_alu_res; n_st = S_C_RX; end
            end
            S_C_RX: begin
                o_alu_req.op = ALU_MUL; o_alu_a = r_rm; o_alu_b = r_dx;
                if (op_fin) begin n_t = i_alu_res; n_st = S_C_RXD; end
            end
            S_C_RXD: begin
                o_alu_req.op = ALU_DIV; o_alu_a = r_t; o_alu_b = r_d2;
                if (op_fin) begin n_cx = r_cx + i_alu_res; n_st = S_C_QY; end
            end
            S_C_QY: begin
                o_alu_req.op = ALU_MUL; o_alu_a = r_q; o_alu_b = r_dy;
                if (op_fin) begin n_cy = i_alu_res; n_st = S_C_RY; end
            end
            S_C_RY: begin
                o_alu_req.op = ALU_MUL; o_alu_a = r_rm; o_alu_b = r_dy;
                if (op_fin) begin n_t = i_alu_res; n_st = S_C_RYD; end
            end
            S_C_RYD: begin
                o_alu_req.op = ALU_DIV; o_alu_a = r_t; o_alu_b = r_d2;
                if (op_fin) begin n_cy = r_cy + i_alu_res; n_st = S_C_U; end
            end
            S_C_U: begin
                n_ux = r_ux - r_cx;
                n_uy = r_uy - r_cy;
                n_st = S_C_MXI;
            end
            S_C_MXI: begin
                o_alu_req.op = ALU_MUL; o_alu_a = sx48(r_pi.vx);
                o_alu_b = {{(W-32){1'b0}}, r_pi.mass};
                if (op_fin) begin n_t = i_alu_res; n_st = S_C_MXJ; end
            end
            S_C_MXJ: begin
                o_alu_req.op = ALU_MUL; o_alu_a = sx48(r_pj.vx);
                o_alu_b = {{(W-32){1'b0}}, r_pj.mass};
                if (op_fin) begin n_t = r_t + i_alu_res; n_st = S_C_CMX; end
            end
            S_C_CMX: begin
                o_alu_req.op = ALU_DIV; o_alu_a = r_t; o_alu_b = {{(W-33){1'b0}}, mw};
                if (op_fin) begin n_cmx = i_alu_res; n_st = S_C_MYI; end
            end
            S_C_MYI: begin
                o_alu_req.op = ALU_MUL; o_alu_a = sx48(r_pi.vy);
                o_alu_b = {{(W-32){1'b0}}, r_pi.mass};
                if (op_fin) begin n_t = i_alu_res; n_st = S_C_MYJ; end
            end
            S_C_MYJ: begin
                o_alu_req.op = ALU_MUL; o_alu_a = sx48(r_pj.vy);
                o_alu_b = {{(W-32){1'b0}}, r_pj.mass};
                if (op_fin) begin n_t = r_t + i_alu_res; n_st = S_C_CMY; end
            end
            S_C_CMY: begin
                o_alu_req.op = ALU_DIV; o_alu_a = r_t; o_alu_b = {{(W-33){1'b0}}, mw};
                if (op_fin) begin n_cmy = i_alu_res; n_st = S_C_VXI; end
            end
            S_C_VXI: begin
                o_alu_req.op = ALU_MUL; o_alu_a = r_ux;
                o_alu_b = {{(W-32){1'b0}}, r_pj.mass};
                if (op_fin) begin n_t = i_alu_res; n_st = S_C_VXID; end
            end
            S_C_VXID: begin
                o_alu_req.op = ALU_DIV; o_alu_a = r_t; o_alu_b = {{(W-33){1'b0}}, mw};
                if (op_fin) begin n_nx = sat48(r_cmx + i_alu_res); n_st = S_C_VYI; end
            end
            S_C_VYI: begin
                o_alu_req.op = ALU_MUL; o_alu_a = r_uy;
                o_alu_b = {{(W-32){1'b0}}, r_pj.mass};
                if (op_fin) begin n_t = i_alu_res; n_st = S_C_VYID; end
            end
            S_C_VYID: begin
                o_alu_req.op = ALU_DIV; o_alu_a = r_t; o_alu_b = {{(W-33){1'b0}}, mw};
                if (op_fin) begin n_ny = sat48(r_cmy + i_alu_res); n_st = S_C_WI; end
            end
            S_C_WI: begin
                wr_addr = IDX_W'(r_i);
                wr_vel  = 1'b1;
                n_st    = S_C_VXJ;
            end
            S_C_VXJ: begin
                o_alu_req.op = ALU_MUL; o_alu_a = r_ux;
                o_alu_b = {{(W-32){1'b0}}, r_pi.mass};
                if (op_fin) begin n_t = i_alu_res; n_st = S_C_VXJD; end
            end
            S_C_VXJD: begin
                o_alu_req.op = ALU_DIV; o_alu_a = r_t; o_alu_b = {{(W-33){1'b0}}, mw};
                if (op_fin) begin n_nx = sat48(r_cmx - i_alu_res); n_st = S_C_VYJ; end
            end
            S_C_VYJ: begin
                o_alu_req.op = ALU_MUL; o_alu_a = r_uy;
                o_alu_b = {{(W-32){1'b0}}, r_pi.mass};
                if (op_fin) begin n_t = i_alu_res; n_st = S_C_VYJD; end
            end
            S_C_VYJD: begin
                o_alu_req.op = ALU_DIV; o_alu_a = r_t; o_alu_b = {{(W-33){1'b0}}, mw};
                if (op_fin) begin n_ny = sat48(r_cmy - i_alu_res); n_st = S_C_WJ; end
            end
            S_C_WJ: begin
                wr_addr = IDX_W'(r_j);
                wr_vel  = 1'b1;
                n_st    = S_NEXT;
            end
            S_NEXT: begin
                n_j  = r_j + 1'b1;
                n_st = S_PJ_START;
            end
            default: n_st = S_IDLE;
        endcase

        o_alu_req.start = (o_alu_req.op != ALU_NOP) && !r_wait;
        n_wait = (o_alu_req.op != ALU_NOP) && !op_fin;
    end

    assign o_idle = (r_st == S_IDLE);

    always_comb begin
        o_res.slot = r_slot;
        if (r_oob) begin
            o_res.pos_x  = '0;
            o_res.pos_y  = '0;
            o_res.vel_x  = '0;
            o_res.vel_y  = '0;
            o_res.leaked = 1'b0;
        end else begin
            o_res.pos_x  = r_rd.px;
            o_res.pos_y  = r_rd.py;
            o_res.vel_x  = r_rd.vx;
            o_res.vel_y  = r_rd.vy;
            o_res.leaked = r_rd.leak;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/particle_drift_and_elastic_collide_core.sv -----
// Top level: config registers, command port, result register, core units.
`default_nettype none
// Hard-disc particle table with drift and elastic pair collisions. Words on
// the input channel carry a command: write (stores one slot, done in the
// accept cycle), read (returns one result word through the S_RD_W and
// S_RD_OUT states into the result register) or step (drift every particle
// in use, then collide every non-leaked pair i<j in order when collisions
// are enabled). All multiplies and divides run through one shared serial
// unit: a multiply works through 64 multiplier bits and a floor divide
// through 128 quotient bits. A step costs two multiplies per particle for
// the drift, three per pair that does not overlap, none when either disc
// is leaked, and 17 multiplies and 9 divides per pair that collides. The
// input channel stalls while a read or step is in progress. A read result
// sits in an output register, so the next command is taken while that word
// waits; a later read holds until the register frees. The user must write
// configuration only while the block is idle; the block does not enforce it.
module particle_drift_and_elastic_collide_core
    import pdec_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_index,
    input  wire logic [31:0] i_mass,
    input  wire logic [47:0] i_pos_x,
    input  wire logic [47:0] i_pos_y,
    input  wire logic [47:0] i_vel_x,
    input  wire logic [47:0] i_vel_y,
    input  wire logic [39:0] i_radius,
    input  wire logic        i_leaked,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_slot,
    output logic [47:0]      o_out_pos_x,
    output logic [47:0]      o_out_pos_y,
    output logic [47:0]      o_out_vel_x,
    output logic [47:0]      o_out_vel_y,
    output logic             o_out_leaked,
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [39:0] i_cfg_data
);

    logic [8:0]  r_count;
    logic [39:0] r_dt;
    logic        r_en;
    logic        r_ovalid;
    t_result     r_ores;

    t_item    item;
    logic     in_acc;
    logic     seq_idle;
    logic     res_valid;
    t_result  res;
    logic     out_free;
    t_alu_req alu_req;
    t_alu_rsp alu_rsp;
    logic signed [W-1:0] alu_a, alu_b, alu_res, alu_rem;

    // config registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dt    <= DT_RESET;
            r_en    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_COUNT:  r_count <= i_cfg_data[8:0];
                CFG_DT:     r_dt    <= i_cfg_data;
                CFG_ENABLE: r_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign item.cmd    = i_cmd;
    assign item.index  = i_index;
    assign item.mass   = i_mass;
    assign item.pos_x  = i_pos_x;
    assign item.pos_y  = i_pos_y;
    assign item.vel_x  = i_vel_x;
    assign item.vel_y  = i_vel_y;
    assign item.radius = i_radius;
    assign item.leaked = i_leaked;

    // commands only enter while the sequencer sits idle
    assign o_stall = !seq_idle;
    assign in_acc  = i_valid && seq_idle;

    // result register frees when empty or when its word leaves this cycle
    assign out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_valid) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
        if (res_valid) r_ores <= res;
    end

    assign o_valid      = r_ovalid;
    assign o_slot       = r_ores.slot;
    assign o_out_pos_x  = r_ores.pos_x;
    assign o_out_pos_y  = r_ores.pos_y;
    assign o_out_vel_x  = r_ores.vel_x;
    assign o_out_vel_y  = r_ores.vel_y;
    assign o_out_leaked = r_ores.leaked;

    pdec_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (in_acc),
        .i_item     (item),
        .i_count    (r_count),
        .i_dt       (r_dt),
        .i_en       (r_en),
        .i_out_free (out_free),
        .o_idle     (seq_idle),
        .o_res_valid(res_valid),
        .o_res      (res),
        .o_alu_req  (alu_req),
        .o_alu_a    (alu_a),
        .o_alu_b    (alu_b),
        .i_alu_rsp  (alu_rsp),
        .i_alu_res  (alu_res),
        .i_alu_rem  (alu_rem)
    );

    pdec_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_rsp  (alu_rsp),
        .o_res  (alu_res),
        .o_rem  (alu_rem)
    );

    // a new result never overwrites a word still waiting downstream
    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (!r_ovalid || !i_stall))
        else $error("result issued while output register held");

    // the arithmetic unit only finishes work for a command in flight
    a_alu_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> !seq_idle)
        else $error("arithmetic unit done while sequencer idle");

    // a step command always leaves the block busy in the cycle after it is accepted
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_cmd == CMD_STEP)) |=> o_stall)
        else $error("step command did not start");

endmodule
`default_nettype wire
